FILE: hdl/bdq_pkg.sv
package bdq_pkg;

	// Ring depth. The ring arithmetic below wraps by one compare and subtract,
	// so any depth from 2 upward works.
	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef logic signed [31:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SUM_W-1:0] sum_t;

	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_POP_BACK   = 3'd1;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_DELETE     = 3'd4;

	localparam cnt_t CNT_FULL = CNT_W'(CAPACITY);
	localparam sum_t SUM_CAP = SUM_W'(CAPACITY);

	// Physical slot of logical position pos, counted from the head. Position
	// never exceeds the depth, so one conditional subtract finishes the wrap.
	function automatic idx_t slot_of(input idx_t head, input cnt_t pos);
		sum_t sum;
		sum = SUM_W'(head) + SUM_W'(pos);
		if (sum >= SUM_CAP) begin
			sum = sum - SUM_CAP;
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: hdl/bounded_deque_with_delete.sv
// Bounded double-ended queue of signed 32-bit words held in a ring memory of
// CAPACITY entries with a head pointer and an entry count. Each input transfer
// carries one operation (push back, pop back, push front, pop front, delete
// first match) and produces exactly one output transfer with the removed word,
// the empty, full and found flags and the occupancy after the operation.
// Pushes, unused codes, pops that find the ring empty and deletes on an empty
// ring load their result at the edge of the transfer, so they can follow one
// another every cycle while the output is taken. A pop of a stored word goes
// through the pop state because the ring has one registered read port: the
// input is stalled while the read lands. A delete is run by a small sequencer
// around that single read port and one comparator. For each entry it searches,
// counted from the front, it passes a read state and a compare state, and for
// each entry behind the match that it moves one place forward, a read state
// and a write state. Every entry is either searched or moved exactly once.
// The input is stalled for the whole delete, which loads its result in its
// last state. The input is also stalled while a finished result is still
// waiting to be taken.
module bounded_deque_with_delete
	import bdq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  word_t       value,
	output logic        out_valid,
	input  logic        out_stall,
	output word_t       data_out,
	output logic        empty_flag,
	output logic        full_flag,
	output logic        found,
	output cnt_t        occupancy
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_POP      = 3'd1;
	localparam logic [2:0] ST_SCAN_RD  = 3'd2;
	localparam logic [2:0] ST_SCAN_CMP = 3'd3;
	localparam logic [2:0] ST_MOVE_RD  = 3'd4;
	localparam logic [2:0] ST_MOVE_WR  = 3'd5;

	logic [2:0] state_q, state_d;
	idx_t       head_q, head_d;
	cnt_t       cnt_q, cnt_d;
	cnt_t       idx_q, idx_d;   // logical position being searched or moved
	word_t      key_q, key_d;
	logic       out_valid_q, out_valid_d;

	// Ring memory: one write port and one registered read port.
	word_t      mem_q [CAPACITY];
	word_t      rd_data_q;
	idx_t       rd_addr;
	logic       wr_en;
	idx_t       wr_addr;
	word_t      wr_data;

	// Result to be loaded into the output register.
	logic       res_load;
	word_t      res_data;
	logic       res_empty;
	logic       res_full;
	logic       res_found;

	word_t      data_q;
	logic       empty_q;
	logic       full_q;
	logic       found_q;
	cnt_t       occ_q;

	logic       in_fire;
	logic       out_fire;
	cnt_t       idx_inc;

	// A new operation is taken only when the sequencer is idle and the output
	// register is empty or drains in this cycle, so a finished result always
	// has a free place to go.
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign idx_inc  = idx_q + cnt_t'(1);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		key_d     = key_q;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = head_q;
		wr_data   = value;
		res_load  = 1'b0;
		res_data  = '0;
		res_empty = 1'b0;
		res_full  = 1'b0;
		res_found = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (operation)
						OP_PUSH_BACK: begin
							res_load = 1'b1;
							if (cnt_q >= CNT_FULL) begin
								res_full = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_addr = slot_of(head_q, cnt_q);
								cnt_d   = cnt_q + cnt_t'(1);
							end
						end
						OP_PUSH_FRONT: begin
							res_load = 1'b1;
							if (cnt_q >= CNT_FULL) begin
								res_full = 1'b1;
							end else begin
								// Stepping back by one is a forward step of depth minus one.
								head_d  = slot_of(head_q, CNT_FULL - cnt_t'(1));
								wr_en   = 1'b1;
								wr_addr = head_d;
								cnt_d   = cnt_q + cnt_t'(1);
							end
						end
						OP_POP_BACK: begin
							if (cnt_q == '0) begin
								res_load  = 1'b1;
								res_empty = 1'b1;
								res_data  = '1;
							end else begin
								cnt_d   = cnt_q - cnt_t'(1);
								rd_addr = slot_of(head_q, cnt_d);
								state_d = ST_POP;
							end
						end
						OP_POP_FRONT: begin
							if (cnt_q == '0) begin
								res_load  = 1'b1;
								res_empty = 1'b1;
								res_data  = '1;
							end else begin
								rd_addr = head_q;
								head_d  = slot_of(head_q, cnt_t'(1));
								cnt_d   = cnt_q - cnt_t'(1);
								state_d = ST_POP;
							end
						end
						OP_DELETE: begin
							key_d = value;
							idx_d = '0;
							if (cnt_q == '0) begin
								res_load = 1'b1;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				// The read issued with the transfer has landed.
				res_load = 1'b1;
				res_data = rd_data_q;
				state_d  = ST_IDLE;
			end
			ST_SCAN_RD: begin
				rd_addr = slot_of(head_q, idx_q);
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (rd_data_q == key_q) begin
					if (idx_inc < cnt_q) begin
						state_d = ST_MOVE_RD;
					end else begin
						// The match was the last entry: nothing to move.
						cnt_d     = cnt_q - cnt_t'(1);
						res_load  = 1'b1;
						res_found = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (idx_inc == cnt_q) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					idx_d   = idx_inc;
					state_d = ST_SCAN_RD;
				end
			end
			ST_MOVE_RD: begin
				rd_addr = slot_of(head_q, idx_inc);
				state_d = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				wr_en   = 1'b1;
				wr_addr = slot_of(head_q, idx_q);
				wr_data = rd_data_q;
				idx_d   = idx_inc;
				if ((idx_inc + cnt_t'(1)) < cnt_q) begin
					state_d = ST_MOVE_RD;
				end else begin
					cnt_d     = cnt_q - cnt_t'(1);
					res_load  = 1'b1;
					res_found = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (res_load) begin
			out_valid_d = 1'b1;
		end else if (out_fire) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Result payload; it only changes when a new result is loaded.
	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (res_load) begin
			data_q  <= res_data;
			empty_q <= res_empty;
			full_q  <= res_full;
			found_q <= res_found;
			occ_q   <= cnt_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = data_q;
	assign empty_flag = empty_q;
	assign full_flag  = full_q;
	assign found      = found_q;
	assign occupancy  = occ_q;

endmodule
